[hw/rtl/sce_pkg.sv]
package sce_pkg;

    // Container constants.
    localparam logic [31:0] FILE_MAGIC = 32'h61786772;
    localparam logic [23:0] MARK_MASK  = 24'hFFFFFF;
    localparam logic [23:0] MARK_VALUE = 24'h112A10;
    localparam logic [2:0]  SKIP_BYTES = 3'd5;

    // Depth of the command queue between the parser and the result sequencer.
    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

    // Parser phases.
    typedef enum logic [3:0] {
        PH_MAGIC    = 4'd0,
        PH_VCOUNT   = 4'd1,
        PH_VARCOUNT = 4'd2,
        PH_VTYPE    = 4'd3,
        PH_VINDEX   = 4'd4,
        PH_VU16     = 4'd5,
        PH_VNAMELEN = 4'd6,
        PH_VNAME    = 4'd7,
        PH_SIZE1    = 4'd8,
        PH_SIZE2    = 4'd9,
        PH_CODE     = 4'd10,
        PH_PCOUNT   = 4'd11,
        PH_PSKIP    = 4'd12,
        PH_DONE     = 4'd13,
        PH_BAD      = 4'd14
    } t_phase;

    // One input item.
    typedef struct packed {
        logic [7:0] file_byte;
        logic       end_of_file;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic       result_kind;
        logic       is_pixel;
        logic [7:0] fragment_number;
        logic [7:0] shader_byte;
        logic       last_of_shader;
        logic       parse_ok;
    } t_out_item;

    // Work for the result sequencer: up to three window bytes, one shader byte
    // and one status result, produced in that order.
    typedef struct packed {
        logic        has_window;
        logic        has_byte;
        logic        has_status;
        logic        parse_ok;
        logic        is_pixel;
        logic [7:0]  fragment_number;
        logic [23:0] window;
        logic [7:0]  shader_byte;
        logic        last;
    } t_cmd;

endpackage

[hw/rtl/sce_front.sv]
module sce_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sce_pkg::t_in_item i_item,
    input  logic              i_cmd_full,
    output logic              o_cmd_write,
    output sce_pkg::t_cmd     o_cmd
);

    sce_pkg::t_phase r_phase, n_phase;
    logic [2:0]  r_fc, n_fc;
    logic [7:0]  r_acc, n_acc;
    logic        r_magic_ok, n_magic_ok;
    logic [7:0]  r_vleft, n_vleft;
    logic [7:0]  r_pleft, n_pleft;
    logic [7:0]  r_fidx, n_fidx;
    logic [7:0]  r_vars, n_vars;
    logic [7:0]  r_nleft, n_nleft;
    logic [15:0] r_bcl, n_bcl;
    logic [23:0] r_window, n_window;
    logic [1:0]  r_fill, n_fill;
    logic        r_found, n_found;
    logic        r_pix, n_pix;

    logic        accept;
    logic [7:0]  b;
    logic [15:0] bc_dec;
    logic [7:0]  vars_dec;
    logic [7:0]  name_dec;
    logic [7:0]  vleft_dec;
    logic [7:0]  pleft_dec;
    logic        do_end;
    logic        do_next_var;
    logic        bad;
    sce_pkg::t_cmd cmd;

    assign accept    = i_push && !i_cmd_full;
    assign b         = i_item.file_byte;
    assign bc_dec    = r_bcl - 16'd1;
    assign vars_dec  = r_vars - 8'd1;
    assign name_dec  = r_nleft - 8'd1;
    assign vleft_dec = r_vleft - 8'd1;
    assign pleft_dec = r_pleft - 8'd1;

    // Field parser: one byte a cycle while the command queue has room, with the work for the result side.
    always_comb begin
        n_phase    = r_phase;
        n_fc       = r_fc;
        n_acc      = r_acc;
        n_magic_ok = r_magic_ok;
        n_vleft    = r_vleft;
        n_pleft    = r_pleft;
        n_fidx     = r_fidx;
        n_vars     = r_vars;
        n_nleft    = r_nleft;
        n_bcl      = r_bcl;
        n_window   = r_window;
        n_fill     = r_fill;
        n_found    = r_found;
        n_pix      = r_pix;
        do_end      = 1'b0;
        do_next_var = 1'b0;
        bad         = 1'b0;
        cmd                 = '0;
        cmd.is_pixel        = r_pix;
        cmd.fragment_number = r_fidx;
        cmd.window          = r_window;
        cmd.shader_byte     = b;

        if (accept) begin
            unique case (r_phase)
                sce_pkg::PH_MAGIC: begin
                    n_magic_ok = r_magic_ok &&
                                 (b == sce_pkg::FILE_MAGIC[8*r_fc[1:0] +: 8]);
                    n_fc = r_fc + 3'd1;
                    if (r_fc == 3'd3) begin
                        n_phase    = n_magic_ok ? sce_pkg::PH_VCOUNT : sce_pkg::PH_BAD;
                        n_fc       = '0;
                        n_magic_ok = 1'b1;
                    end
                end
                sce_pkg::PH_VCOUNT: begin
                    n_vleft = b;
                    n_pix   = 1'b0;
                    n_fidx  = '0;
                    if (b == 8'd0) begin
                        n_phase = sce_pkg::PH_PCOUNT;
                    end else begin
                        n_phase = sce_pkg::PH_VARCOUNT;
                        n_fc    = '0;
                        n_acc   = '0;
                    end
                end
                sce_pkg::PH_VARCOUNT: begin
                    n_vars  = b;
                    n_fc    = '0;
                    n_acc   = '0;
                    n_phase = (b == 8'd0) ? sce_pkg::PH_SIZE1 : sce_pkg::PH_VTYPE;
                end
                sce_pkg::PH_VTYPE: begin
                    n_phase = sce_pkg::PH_VINDEX;
                end
                sce_pkg::PH_VINDEX: begin
                    n_phase = sce_pkg::PH_VU16;
                    n_fc    = '0;
                end
                sce_pkg::PH_VU16: begin
                    if (r_fc != 3'd0) begin
                        n_fc    = '0;
                        n_phase = sce_pkg::PH_VNAMELEN;
                    end else begin
                        n_fc = 3'd1;
                    end
                end
                sce_pkg::PH_VNAMELEN: begin
                    n_nleft = b;
                    if (b == 8'd0) begin
                        do_next_var = 1'b1;
                    end else begin
                        n_phase = sce_pkg::PH_VNAME;
                    end
                end
                sce_pkg::PH_VNAME: begin
                    n_nleft = name_dec;
                    do_next_var = (name_dec == 8'd0);
                end
                sce_pkg::PH_SIZE1: begin
                    if (r_fc == 3'd0) begin
                        n_acc = b;
                        n_fc  = 3'd1;
                    end else begin
                        n_bcl   = {b, r_acc};
                        n_fc    = '0;
                        n_acc   = '0;
                        n_phase = sce_pkg::PH_SIZE2;
                    end
                end
                sce_pkg::PH_SIZE2: begin
                    if (r_fc == 3'd0) begin
                        n_fc = 3'd1;
                    end else begin
                        n_fc     = '0;
                        n_window = '0;
                        n_fill   = '0;
                        n_found  = 1'b0;
                        if (r_bcl == 16'd0) begin
                            do_end = 1'b1;
                        end else begin
                            n_phase = sce_pkg::PH_CODE;
                        end
                    end
                end
                sce_pkg::PH_CODE: begin
                    n_bcl    = bc_dec;
                    cmd.last = (bc_dec == 16'd0);
                    if (r_found) begin
                        cmd.has_byte = 1'b1;
                    end else if (r_fill == 2'd3 &&
                                 (r_window & sce_pkg::MARK_MASK) == sce_pkg::MARK_VALUE) begin
                        n_found        = 1'b1;
                        cmd.has_window = 1'b1;
                        cmd.has_byte   = 1'b1;
                    end else begin
                        n_window = {b, r_window[23:8]};
                        if (r_fill != 2'd3) begin
                            n_fill = r_fill + 2'd1;
                        end
                    end
                    do_end = (bc_dec == 16'd0);
                end
                sce_pkg::PH_PCOUNT: begin
                    n_pleft = (b != 8'd0) ? b - 8'd1 : 8'd0;
                    n_fc    = '0;
                    n_phase = sce_pkg::PH_PSKIP;
                end
                sce_pkg::PH_PSKIP: begin
                    n_fc = r_fc + 3'd1;
                    if (n_fc == sce_pkg::SKIP_BYTES) begin
                        n_fc = '0;
                        if (r_pleft == 8'd0) begin
                            n_phase = sce_pkg::PH_DONE;
                        end else begin
                            n_pix   = 1'b1;
                            n_fidx  = '0;
                            n_phase = sce_pkg::PH_VARCOUNT;
                            n_acc   = '0;
                        end
                    end
                end
                default: begin
                end
            endcase

            // Move on to the next variable, or to the sizes after the last one.
            if (do_next_var) begin
                n_vars  = vars_dec;
                n_fc    = '0;
                n_acc   = '0;
                n_phase = (vars_dec == 8'd0) ? sce_pkg::PH_SIZE1 : sce_pkg::PH_VTYPE;
            end

            // Close a fragment and pick the next one, the next group, or the end.
            if (do_end) begin
                n_fidx = r_fidx + 8'd1;
                if (!r_pix) begin
                    n_vleft = vleft_dec;
                    if (vleft_dec == 8'd0) begin
                        n_phase = sce_pkg::PH_PCOUNT;
                    end else begin
                        n_phase = sce_pkg::PH_VARCOUNT;
                        n_fc    = '0;
                        n_acc   = '0;
                    end
                end else begin
                    n_pleft = pleft_dec;
                    if (pleft_dec == 8'd0) begin
                        n_phase = sce_pkg::PH_DONE;
                    end else begin
                        n_phase = sce_pkg::PH_VARCOUNT;
                        n_fc    = '0;
                        n_acc   = '0;
                    end
                end
            end

            // On the final byte the status is judged and all state starts over.
            if (i_item.end_of_file) begin
                bad = (n_phase == sce_pkg::PH_MAGIC) || (n_phase == sce_pkg::PH_BAD) ||
                      (n_phase == sce_pkg::PH_CODE && n_bcl != 16'd0) ||
                      (n_phase == sce_pkg::PH_SIZE2 && n_bcl != 16'd0) ||
                      (n_phase == sce_pkg::PH_SIZE1 && n_fc == 3'd1 && n_acc != 8'd0);
                cmd.has_status = 1'b1;
                cmd.parse_ok   = !bad;
                n_phase    = sce_pkg::PH_MAGIC;
                n_fc       = '0;
                n_acc      = '0;
                n_magic_ok = 1'b1;
                n_vleft    = '0;
                n_pleft    = '0;
                n_fidx     = '0;
                n_vars     = '0;
                n_nleft    = '0;
                n_bcl      = '0;
                n_window   = '0;
                n_fill     = '0;
                n_found    = 1'b0;
                n_pix      = 1'b0;
            end
        end
    end

    assign o_cmd       = cmd;
    assign o_cmd_write = accept && (cmd.has_byte || cmd.has_status);

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= sce_pkg::PH_MAGIC;
            r_fc       <= '0;
            r_acc      <= '0;
            r_magic_ok <= 1'b1;
            r_vleft    <= '0;
            r_pleft    <= '0;
            r_fidx     <= '0;
            r_vars     <= '0;
            r_nleft    <= '0;
            r_bcl      <= '0;
            r_window   <= '0;
            r_fill     <= '0;
            r_found    <= 1'b0;
            r_pix      <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_fc       <= n_fc;
            r_acc      <= n_acc;
            r_magic_ok <= n_magic_ok;
            r_vleft    <= n_vleft;
            r_pleft    <= n_pleft;
            r_fidx     <= n_fidx;
            r_vars     <= n_vars;
            r_nleft    <= n_nleft;
            r_bcl      <= n_bcl;
            r_window   <= n_window;
            r_fill     <= n_fill;
            r_found    <= n_found;
            r_pix      <= n_pix;
        end
    end

endmodule

[hw/rtl/sce_cmd_fifo.sv]
module sce_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_write,
    input  sce_pkg::t_cmd i_cmd,
    input  logic          i_read,
    output logic          o_full,
    output logic          o_empty,
    output sce_pkg::t_cmd o_head
);

    sce_pkg::t_cmd r_mem [sce_pkg::CMD_DEPTH];
    logic [sce_pkg::CMD_PTR_W-1:0] r_wr, n_wr;
    logic [sce_pkg::CMD_PTR_W-1:0] r_rd, n_rd;
    logic [sce_pkg::CMD_PTR_W:0]   r_count, n_count;
    logic do_write;
    logic do_read;

    assign o_full   = (r_count == (sce_pkg::CMD_PTR_W+1)'(sce_pkg::CMD_DEPTH));
    assign o_empty  = (r_count == '0);
    assign do_write = i_write && !o_full;
    assign do_read  = i_read && !o_empty;
    assign o_head   = r_mem[r_rd];

    // Pointer and occupancy update.
    always_comb begin
        n_wr    = do_write ? r_wr + 1'b1 : r_wr;
        n_rd    = do_read ? r_rd + 1'b1 : r_rd;
        n_count = r_count + (sce_pkg::CMD_PTR_W+1)'(do_write)
                          - (sce_pkg::CMD_PTR_W+1)'(do_read);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

[hw/rtl/sce_back.sv]
module sce_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_empty,
    input  sce_pkg::t_cmd      i_head,
    output logic               o_cmd_read,
    input  logic               i_pop,
    output logic               o_empty,
    output sce_pkg::t_out_item o_result
);

    logic [2:0] r_sub, n_sub;
    logic       r_valid, n_valid;
    sce_pkg::t_out_item r_item, n_item;

    logic [2:0] win_n;
    logic [2:0] total;
    logic       load;
    logic       final_sub;
    sce_pkg::t_out_item cur;

    assign win_n     = i_head.has_window ? 3'd3 : 3'd0;
    assign total     = win_n + 3'(i_head.has_byte) + 3'(i_head.has_status);
    assign final_sub = (r_sub == total - 3'd1);
    assign load      = !i_cmd_empty && (!r_valid || i_pop);

    // Select the result at the current position within the head command.
    always_comb begin
        cur                 = '0;
        cur.is_pixel        = i_head.is_pixel;
        cur.fragment_number = i_head.fragment_number;
        if (r_sub < win_n) begin
            cur.shader_byte = i_head.window[8*r_sub[1:0] +: 8];
        end else if (r_sub == win_n && i_head.has_byte) begin
            cur.shader_byte    = i_head.shader_byte;
            cur.last_of_shader = i_head.last;
        end else begin
            cur.result_kind     = 1'b1;
            cur.is_pixel        = 1'b0;
            cur.fragment_number = '0;
            cur.parse_ok        = i_head.parse_ok;
        end
    end

    // Output register and position counter.
    always_comb begin
        n_sub   = r_sub;
        n_valid = r_valid;
        n_item  = r_item;
        if (i_pop && r_valid) begin
            n_valid = 1'b0;
        end
        if (load) begin
            n_valid = 1'b1;
            n_item  = cur;
            n_sub   = final_sub ? 3'd0 : r_sub + 3'd1;
        end
    end

    assign o_cmd_read = load && final_sub;
    assign o_empty    = !r_valid;
    assign o_result   = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_sub   <= n_sub;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

endmodule

[hw/rtl/shader_container_extractor_core.sv]
// Channel   | Handshake           | Payload
// ----------+---------------------+-----------------------------------------
// input     | push in, full out   | i_item   (file_byte, end_of_file)
// result    | pop in, empty out   | o_result (kind, pixel, fragment, byte,
//           |                     |           last, ok)
//
// The parser takes one byte a cycle while the command queue has room.
// A byte that yields results is sequenced one result at a time: up to
// five when a marker is found on the final byte, so bursts are absorbed by
// the four-entry command queue and the output register.
// A result passes through the command queue and the output register before it is on the result ports.
// Reset is synchronous and active low; no clearing pass is needed.

module shader_container_extractor_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  sce_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output sce_pkg::t_out_item o_result
);

    logic          cmd_write;
    logic          cmd_read;
    logic          cmd_full;
    logic          cmd_empty;
    sce_pkg::t_cmd cmd_in;
    sce_pkg::t_cmd cmd_head;

    assign full = cmd_full;

    // Parser front end.
    sce_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .i_cmd_full  (cmd_full),
        .o_cmd_write (cmd_write),
        .o_cmd       (cmd_in)
    );

    // Command queue between the two halves.
    sce_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_write (cmd_write),
        .i_cmd   (cmd_in),
        .i_read  (cmd_read),
        .o_full  (cmd_full),
        .o_empty (cmd_empty),
        .o_head  (cmd_head)
    );

    // Result sequencer.
    sce_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_head      (cmd_head),
        .o_cmd_read  (cmd_read),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

endmodule
